/* hw/rtl/multi_button_debounce_long_press_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the button debouncer
// Shared concurrent-check wrappers, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef MULTI_BUTTON_DEBOUNCE_LONG_PRESS_MACROS_SVH
`define MULTI_BUTTON_DEBOUNCE_LONG_PRESS_MACROS_SVH

// same-cycle implication
`define MBDLP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MBDLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/mbdlp_pkg.sv */
// ----------------------------------------------------------------------------
// mbdlp_pkg
// Types and constants shared by the button debouncer modules.
// ----------------------------------------------------------------------------
package mbdlp_pkg;

    localparam int BUTTONS_DEFAULT = 8;
    localparam int MASK_W          = 8;
    localparam int IDX_W           = 3;
    localparam int DEB_W           = 16;
    localparam int DUR_W           = 32;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 32;

    localparam logic [DEB_W-1:0] DEBOUNCE_DEFAULT   = 16'd50;
    localparam logic [DUR_W-1:0] LONG_PRESS_DEFAULT = 32'd1000;

    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLED_MASK    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS      = 2'd3;

    typedef struct packed {
        cmd_t              command;
        logic [MASK_W-1:0] pin_levels;
        logic [IDX_W-1:0]  button_index;
    } in_item_t;

    typedef struct packed {
        logic              press_seen;
        logic              release_seen;
        logic              long_press_seen;
        logic              is_held;
        logic [DUR_W-1:0]  held_duration;
        logic [MASK_W-1:0] held_levels;
    } out_item_t;

    // per-lane strobes from the top level
    typedef struct packed {
        logic tick;
        logic clear;
        logic level;     // polarity-corrected pin level
    } lane_ctrl_t;

    typedef struct packed {
        logic [DEB_W-1:0] deb;
        logic [DUR_W-1:0] lng;
    } lane_cfg_t;

    typedef struct packed {
        logic             press_flag;
        logic             release_flag;
        logic             long_flag;
        logic             filt;
        logic             filt_next;  // filtered level after the current item
        logic [DUR_W-1:0] press_ticks;
    } lane_status_t;

endpackage

/* hw/rtl/mbdlp_lane.sv */
// ----------------------------------------------------------------------------
// mbdlp_lane
// One button: stability counter, filtered level, edge and long-press flags.
// ----------------------------------------------------------------------------
module mbdlp_lane (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  mbdlp_pkg::lane_ctrl_t    ctrl,
    input  mbdlp_pkg::lane_cfg_t     cfg,
    output mbdlp_pkg::lane_status_t  stat
);

`include "multi_button_debounce_long_press_macros.svh"

    logic                        last_reg, last_next;
    logic                        filt_reg, filt_next;
    logic [mbdlp_pkg::DEB_W-1:0] stable_reg, stable_next;
    logic [mbdlp_pkg::DUR_W-1:0] press_ticks_reg, press_ticks_next;
    logic                        press_reg, press_next;
    logic                        release_reg, release_next;
    logic                        long_reg, long_next;
    logic                        done_reg, done_next;

    always_comb begin
        last_next        = last_reg;
        filt_next        = filt_reg;
        stable_next      = stable_reg;
        press_ticks_next = press_ticks_reg;
        press_next       = press_reg;
        release_next     = release_reg;
        long_next        = long_reg;
        done_next        = done_reg;
        if (ctrl.tick) begin
            if (filt_reg && (press_ticks_reg != '1)) begin
                press_ticks_next = press_ticks_reg + 1'b1;
            end
            if (ctrl.level != last_reg) begin
                last_next   = ctrl.level;
                stable_next = '0;
            end else if (stable_reg != '1) begin
                stable_next = stable_reg + 1'b1;
            end
            if (stable_next >= cfg.deb) begin
                filt_next = ctrl.level;
                if (!filt_reg && ctrl.level) begin
                    press_next       = 1'b1;
                    press_ticks_next = '0;
                    done_next        = 1'b0;
                end
                if (filt_reg && !ctrl.level) begin
                    release_next = 1'b1;
                end
                if (ctrl.level && !done_next && (press_ticks_next >= cfg.lng)) begin
                    long_next = 1'b1;
                    done_next = 1'b1;
                end
            end
        end else if (ctrl.clear) begin
            press_next   = 1'b0;
            release_next = 1'b0;
            long_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg        <= 1'b0;
            filt_reg        <= 1'b0;
            stable_reg      <= '0;
            press_ticks_reg <= '0;
            press_reg       <= 1'b0;
            release_reg     <= 1'b0;
            long_reg        <= 1'b0;
            done_reg        <= 1'b0;
        end else begin
            last_reg        <= last_next;
            filt_reg        <= filt_next;
            stable_reg      <= stable_next;
            press_ticks_reg <= press_ticks_next;
            press_reg       <= press_next;
            release_reg     <= release_next;
            long_reg        <= long_next;
            done_reg        <= done_next;
        end
    end

    assign stat.press_flag   = press_reg;
    assign stat.release_flag = release_reg;
    assign stat.long_flag    = long_reg;
    assign stat.filt         = filt_reg;
    assign stat.filt_next    = filt_next;
    assign stat.press_ticks  = press_ticks_reg;

    // a new press edge always restarts the held counter
    `MBDLP_ASSERT_NOW(a_press_restarts, aclk, aresetn, ($rose(press_reg) && filt_reg && !$past(filt_reg)), (press_ticks_reg == '0), "press edge without held counter restart")
    // long-press flag only rises together with its one-shot marker
    `MBDLP_ASSERT_NOW(a_long_one_shot, aclk, aresetn, $rose(long_reg), (done_reg && filt_reg), "long-press flag set without one-shot marker")

endmodule

/* hw/rtl/mbdlp_merge.sv */
// ----------------------------------------------------------------------------
// mbdlp_merge
// Picks the queried lane, gathers held levels, and holds results in a
// two-entry output buffer.
// ----------------------------------------------------------------------------
module mbdlp_merge #(
    parameter int LANES = mbdlp_pkg::BUTTONS_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     accept,
    input  mbdlp_pkg::in_item_t      item,
    input  logic [LANES-1:0]         enabled,
    input  mbdlp_pkg::lane_status_t  lane_stat [LANES],
    output logic                     s_ready,
    output logic                     m_valid,
    input  logic                     m_ready,
    output mbdlp_pkg::out_item_t     m_item
);

`include "multi_button_debounce_long_press_macros.svh"

    mbdlp_pkg::out_item_t    res;
    mbdlp_pkg::lane_status_t sel;
    logic                    hit;

    mbdlp_pkg::out_item_t out_reg;
    mbdlp_pkg::out_item_t skid_reg;
    logic                 out_valid_reg;
    logic                 skid_valid_reg;

    always_comb begin
        sel = '0;
        hit = 1'b0;
        for (int i = 0; i < LANES; i++) begin
            if (item.button_index == mbdlp_pkg::IDX_W'(i)) begin
                sel = lane_stat[i];
                hit = enabled[i];
            end
        end
        res = '0;
        if ((item.command == mbdlp_pkg::CMD_QUERY) && hit) begin
            res.press_seen      = sel.press_flag;
            res.release_seen    = sel.release_flag;
            res.long_press_seen = sel.long_flag;
            res.is_held         = sel.filt;
            res.held_duration   = sel.filt ? sel.press_ticks : '0;
        end
        for (int i = 0; i < LANES; i++) begin
            res.held_levels[i] = enabled[i] & lane_stat[i].filt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_valid_reg && m_ready) begin
            if (skid_valid_reg) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end else if (accept) begin
                out_reg <= res;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end else if (accept) begin
            if (!out_valid_reg) begin
                out_reg       <= res;
                out_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= res;
                skid_valid_reg <= 1'b1;
            end
        end
    end

    assign s_ready = !skid_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

    `MBDLP_ASSERT_NOW(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg, "skid entry held with empty output stage")
    `MBDLP_ASSERT_NEXT(a_stall_fills_skid, aclk, aresetn, (accept && out_valid_reg && !m_ready), skid_valid_reg, "item accepted under stall was not buffered")
    `MBDLP_ASSERT_NOW(a_duration_when_held, aclk, aresetn, (out_valid_reg && (out_reg.held_duration != '0)), out_reg.is_held, "held duration reported for a released button")

endmodule

/* hw/rtl/multi_button_debounce_long_press.sv */
// ----------------------------------------------------------------------------
// multi_button_debounce_long_press
// Debouncer for up to eight buttons with press, release and long-press flags.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel (valid/ready) takes items. A tick item (command = CMD_TICK)
//   carries the raw pin levels of all buttons; a query item (CMD_QUERY)
//   reads one button's press/release/long-press flags, held state and held
//   duration, then clears its flags. Every item gives exactly one result
//   item on the m_* channel; held_levels always shows the filtered level of
//   every enabled button after the item.
//   Configuration: cfg_we/cfg_index/cfg_wdata write the enable mask, the
//   active-low mask, the debounce time and the long-press time; write only
//   while no item is in flight. A zero time falls back to the default.
//   Throughput: one item per cycle while s_ready is high; all button lanes
//   update in parallel in the cycle the item is accepted. Each result is
//   registered in the output buffer before it is shown on the m_* channel.
//   Stall: a two-entry output buffer keeps taking items while one result
//   waits; s_ready drops only when both entries are full.
//   Reset (aresetn low, synchronous): all button state and flags clear,
//   registers return to their defaults, buffer empties.
// ----------------------------------------------------------------------------
module multi_button_debounce_long_press #(
    parameter int BUTTONS = mbdlp_pkg::BUTTONS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_we,
    input  logic [mbdlp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mbdlp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // input items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  mbdlp_pkg::in_item_t                 s_item,
    // result items
    output logic                                m_valid,
    input  logic                                m_ready,
    output mbdlp_pkg::out_item_t                m_item
);

    // only the first eight buttons have mask bits; the rest never exist
    localparam int LANES = (BUTTONS < mbdlp_pkg::MASK_W) ? BUTTONS : mbdlp_pkg::MASK_W;

    logic [mbdlp_pkg::MASK_W-1:0] enabled_mask_reg;
    logic [mbdlp_pkg::MASK_W-1:0] active_low_mask_reg;
    logic [mbdlp_pkg::DEB_W-1:0]  debounce_reg;
    logic [mbdlp_pkg::DUR_W-1:0]  long_press_reg;

    // register file; writes are plain, no read-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_mask_reg    <= '0;
            active_low_mask_reg <= '1;
            debounce_reg        <= mbdlp_pkg::DEBOUNCE_DEFAULT;
            long_press_reg      <= mbdlp_pkg::LONG_PRESS_DEFAULT;
        end else if (cfg_we) begin
            case (cfg_index)
                mbdlp_pkg::REG_ENABLED_MASK:
                    enabled_mask_reg <= cfg_wdata[mbdlp_pkg::MASK_W-1:0];
                mbdlp_pkg::REG_ACTIVE_LOW_MASK:
                    active_low_mask_reg <= cfg_wdata[mbdlp_pkg::MASK_W-1:0];
                mbdlp_pkg::REG_DEBOUNCE_TICKS:
                    debounce_reg <= cfg_wdata[mbdlp_pkg::DEB_W-1:0];
                mbdlp_pkg::REG_LONG_PRESS:
                    long_press_reg <= cfg_wdata[mbdlp_pkg::DUR_W-1:0];
                default: ;
            endcase
        end
    end

    logic                    accept;
    mbdlp_pkg::lane_cfg_t    lane_cfg;
    mbdlp_pkg::lane_status_t lane_stat [LANES];

    assign accept = s_valid && s_ready;

    // zero times fall back to the defaults
    assign lane_cfg.deb = (debounce_reg == '0) ? mbdlp_pkg::DEBOUNCE_DEFAULT : debounce_reg;
    assign lane_cfg.lng = (long_press_reg == '0) ? mbdlp_pkg::LONG_PRESS_DEFAULT
                                                 : long_press_reg;

    // one lane per button; disabled lanes see no strobes and hold state
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        mbdlp_pkg::lane_ctrl_t ctrl;

        assign ctrl.tick  = accept && (s_item.command == mbdlp_pkg::CMD_TICK)
                            && enabled_mask_reg[g];
        assign ctrl.clear = accept && (s_item.command == mbdlp_pkg::CMD_QUERY)
                            && enabled_mask_reg[g]
                            && (s_item.button_index == mbdlp_pkg::IDX_W'(g));
        assign ctrl.level = s_item.pin_levels[g] ^ active_low_mask_reg[g];

        mbdlp_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .cfg     (lane_cfg),
            .stat    (lane_stat[g])
        );
    end

    // query select, held-level gather, output buffer
    mbdlp_merge #(
        .LANES (LANES)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .item      (s_item),
        .enabled   (enabled_mask_reg[LANES-1:0]),
        .lane_stat (lane_stat),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule
